// ===== sv/dtscw_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dtscw_pkg: shared types and constants of the date-time string checker
// Layout of "YYYY/MM/DD HH:MM:SS", status codes, calendar tables and the
// records that pass between the stages.
// ----------------------------------------------------------------------------
package dtscw_pkg;

    localparam int unsigned CHAR_W     = 8;
    localparam int unsigned STR_LEN    = 19;
    localparam int unsigned POS_SAT    = 20;
    localparam int unsigned NUM_DIGITS = 14;
    localparam int unsigned POS_W      = 5;
    localparam int unsigned SLOT_W     = 4;
    localparam int unsigned PAIR_W     = 7;

    localparam int unsigned YEAR_W    = 14;
    localparam int unsigned MONTH_W   = 4;
    localparam int unsigned DAY_W     = 5;
    localparam int unsigned WEEKDAY_W = 3;
    localparam int unsigned HOURS_W   = 5;
    localparam int unsigned MINUTES_W = 6;
    localparam int unsigned SECONDS_W = 6;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

    localparam logic [PAIR_W-1:0] MAX_MONTH   = 7'd12;
    localparam logic [PAIR_W-1:0] MAX_HOURS   = 7'd23;
    localparam logic [PAIR_W-1:0] MAX_MINUTES = 7'd59;
    localparam logic [PAIR_W-1:0] MAX_SECONDS = 7'd59;
    localparam logic [PAIR_W-1:0] MAX_YY      = 7'd99;
    localparam logic [PAIR_W-1:0] MONTH_MAR   = 7'd3;

    typedef enum logic [1:0] {
        STATUS_VALID  = 2'd0,
        STATUS_FORMAT = 2'd1,
        STATUS_RANGE  = 2'd2
    } status_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last_char;
    } char_word_t;

    typedef struct packed {
        logic              fmt_err;
        logic [PAIR_W-1:0] cen;
        logic [PAIR_W-1:0] yy;
        logic [PAIR_W-1:0] mon;
        logic [PAIR_W-1:0] day;
        logic [PAIR_W-1:0] hr;
        logic [PAIR_W-1:0] mn;
        logic [PAIR_W-1:0] sc;
    } scan_rec_t;

    typedef struct packed {
        status_t                status;
        logic [YEAR_W-1:0]      year;
        logic [MONTH_W-1:0]     month;
        logic [DAY_W-1:0]       day;
        logic [WEEKDAY_W-1:0]   weekday;
        logic [HOURS_W-1:0]     hours;
        logic [MINUTES_W-1:0]   minutes;
        logic [SECONDS_W-1:0]   seconds;
    } result_t;

    function automatic logic is_digit_pos(input logic [POS_W-1:0] p);
        unique case (p)
            5'd4, 5'd7, 5'd10, 5'd13, 5'd16: is_digit_pos = 1'b0;
            default:                         is_digit_pos = 1'b1;
        endcase
    endfunction

    function automatic logic [SLOT_W-1:0] digit_slot(input logic [POS_W-1:0] p);
        unique case (p)
            5'd0:    digit_slot = 4'd0;
            5'd1:    digit_slot = 4'd1;
            5'd2:    digit_slot = 4'd2;
            5'd3:    digit_slot = 4'd3;
            5'd5:    digit_slot = 4'd4;
            5'd6:    digit_slot = 4'd5;
            5'd8:    digit_slot = 4'd6;
            5'd9:    digit_slot = 4'd7;
            5'd11:   digit_slot = 4'd8;
            5'd12:   digit_slot = 4'd9;
            5'd14:   digit_slot = 4'd10;
            5'd15:   digit_slot = 4'd11;
            5'd17:   digit_slot = 4'd12;
            5'd18:   digit_slot = 4'd13;
            default: digit_slot = 4'd0;
        endcase
    endfunction

    function automatic logic [CHAR_W-1:0] sep_char(input logic [POS_W-1:0] p);
        unique case (p)
            5'd4, 5'd7:   sep_char = CHAR_SLASH;
            5'd10:        sep_char = CHAR_SPACE;
            default:      sep_char = CHAR_COLON;
        endcase
    endfunction

    function automatic logic [PAIR_W-1:0] pair_value(input logic [3:0] hi,
                                                     input logic [3:0] lo);
        pair_value = PAIR_W'({hi, 3'b000}) + PAIR_W'({hi, 1'b0}) + PAIR_W'(lo);
    endfunction

    function automatic logic [2:0] month_offset(input logic [PAIR_W-1:0] m);
        unique case (m)
            7'd1:    month_offset = 3'd0;
            7'd2:    month_offset = 3'd3;
            7'd3:    month_offset = 3'd2;
            7'd4:    month_offset = 3'd5;
            7'd5:    month_offset = 3'd0;
            7'd6:    month_offset = 3'd3;
            7'd7:    month_offset = 3'd5;
            7'd8:    month_offset = 3'd1;
            7'd9:    month_offset = 3'd4;
            7'd10:   month_offset = 3'd6;
            7'd11:   month_offset = 3'd2;
            7'd12:   month_offset = 3'd4;
            default: month_offset = 3'd0;
        endcase
    endfunction

    function automatic logic [DAY_W-1:0] days_in_month(input logic [PAIR_W-1:0] m,
                                                       input logic leap);
        unique case (m)
            7'd4, 7'd6, 7'd9, 7'd11: days_in_month = 5'd30;
            7'd2:                    days_in_month = leap ? 5'd29 : 5'd28;
            default:                 days_in_month = 5'd31;
        endcase
    endfunction

endpackage
`default_nettype wire

// ===== sv/datetime_string_check_weekday_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// datetime_string_check_weekday_unit: date-time string checker
// Takes "YYYY/MM/DD HH:MM:SS" one character word per cycle while in_stall is low
// and gives one result word per string: status, the parsed fields and the weekday.
// ----------------------------------------------------------------------------
// The unit takes one character word in every cycle with no gaps of its own;
// in_stall is registered and rises only when the output side has been
// stalled long enough to fill the input skid entry. Each word passes an
// input register, the scanner register and the result register; the input
// register loads at the edge that takes the word, after which the scanner
// registers the string's digit pairs and then the result register its result
// word. Status 1 flags a wrong length, a non-digit or a wrong separator;
// status 2 flags a field outside its calendar range (Gregorian leap years);
// the value fields and weekday (0 is Sunday) are zero unless status is 0.
module datetime_string_check_weekday_unit (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [dtscw_pkg::CHAR_W-1:0]         char_code,
    input  wire logic                                 last_char,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [1:0]                                status,
    output logic [dtscw_pkg::YEAR_W-1:0]              year,
    output logic [dtscw_pkg::MONTH_W-1:0]             month,
    output logic [dtscw_pkg::DAY_W-1:0]               day,
    output logic [dtscw_pkg::WEEKDAY_W-1:0]           weekday,
    output logic [dtscw_pkg::HOURS_W-1:0]             hours,
    output logic [dtscw_pkg::MINUTES_W-1:0]           minutes,
    output logic [dtscw_pkg::SECONDS_W-1:0]           seconds
);
    import dtscw_pkg::*;

    char_word_t in_word;
    char_word_t sk_word;
    logic       sk_valid;
    logic       sk_ready;
    scan_rec_t  rec;
    logic       rec_valid;
    logic       rec_ready;
    result_t    res;

    assign in_word.char_code = char_code;
    assign in_word.last_char = last_char;

    dtscw_skid u_skid (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_word  (in_word),
        .in_stall (in_stall),
        .dn_valid (sk_valid),
        .dn_word  (sk_word),
        .dn_ready (sk_ready)
    );

    dtscw_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .w_valid   (sk_valid),
        .w_word    (sk_word),
        .w_ready   (sk_ready),
        .rec_valid (rec_valid),
        .rec       (rec),
        .rec_ready (rec_ready)
    );

    dtscw_eval u_eval (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_valid (rec_valid),
        .rec       (rec),
        .rec_ready (rec_ready),
        .res_valid (out_valid),
        .res       (res),
        .res_stall (out_stall)
    );

    assign status  = res.status;
    assign year    = res.year;
    assign month   = res.month;
    assign day     = res.day;
    assign weekday = res.weekday;
    assign hours   = res.hours;
    assign minutes = res.minutes;
    assign seconds = res.seconds;

endmodule
`default_nettype wire

// ===== sv/dtscw_skid.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dtscw_skid: input register with skid entry
// Registers each incoming word and drives a registered stall toward the
// sender, so the input side never waits on a combinational path.
// ----------------------------------------------------------------------------
module dtscw_skid (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  dtscw_pkg::char_word_t      in_word,
    output logic                       in_stall,
    output logic                       dn_valid,
    output dtscw_pkg::char_word_t      dn_word,
    input  wire logic                  dn_ready
);
    import dtscw_pkg::*;

    logic       valid_reg, valid_next;
    logic       skid_valid_reg, skid_valid_next;
    char_word_t data_reg, data_next;
    char_word_t skid_reg, skid_next;
    logic       in_take;

    assign in_take  = in_valid && !skid_valid_reg;
    assign in_stall = skid_valid_reg;
    assign dn_valid = valid_reg;
    assign dn_word  = data_reg;

    always_comb
    begin
        valid_next      = valid_reg;
        skid_valid_next = skid_valid_reg;
        data_next       = data_reg;
        skid_next       = skid_reg;
        if (!valid_reg || dn_ready)
        begin
            valid_next      = skid_valid_reg || in_take;
            data_next       = skid_valid_reg ? skid_reg : in_word;
            skid_valid_next = 1'b0;
        end
        else if (in_take)
        begin
            // hold the word aside while downstream is blocked
            skid_valid_next = 1'b1;
            skid_next       = in_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg      <= valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        skid_reg <= skid_next;
    end

endmodule
`default_nettype wire

// ===== sv/dtscw_scan.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dtscw_scan: character scanner
// Tracks the position in the string, checks each word against the layout,
// keeps the digits and, on the last word, registers the digit pairs.
// ----------------------------------------------------------------------------
module dtscw_scan (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  w_valid,
    input  dtscw_pkg::char_word_t      w_word,
    output logic                       w_ready,
    output logic                       rec_valid,
    output dtscw_pkg::scan_rec_t       rec,
    input  wire logic                  rec_ready
);
    import dtscw_pkg::*;

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              bad_reg, bad_next;
    logic              rec_valid_reg, rec_valid_next;
    scan_rec_t         rec_reg, rec_next;
    logic [3:0]        digit_reg [NUM_DIGITS];
    logic [3:0]        digit_next [NUM_DIGITS];
    logic              take;
    logic              bad_now;
    logic              is_dig;
    logic [CHAR_W-1:0] dig_off;

    assign w_ready   = !rec_valid_reg || rec_ready;
    assign take      = w_valid && w_ready;
    assign rec_valid = rec_valid_reg;
    assign rec       = rec_reg;
    assign is_dig    = (w_word.char_code >= CHAR_ZERO) && (w_word.char_code <= CHAR_NINE);
    assign dig_off   = w_word.char_code - CHAR_ZERO;

    always_comb
    begin
        digit_next = digit_reg;
        bad_now    = bad_reg;
        if (pos_reg < POS_W'(STR_LEN))
        begin
            if (is_digit_pos(pos_reg))
            begin
                if (is_dig)
                    digit_next[digit_slot(pos_reg)] = dig_off[3:0];
                else
                    bad_now = 1'b1;
            end
            else if (w_word.char_code != sep_char(pos_reg))
            begin
                bad_now = 1'b1;
            end
        end

        pos_next = pos_reg;
        bad_next = bad_reg;
        if (take)
        begin
            if (w_word.last_char)
            begin
                pos_next = '0;
                bad_next = 1'b0;
            end
            else
            begin
                bad_next = bad_now;
                if (pos_reg < POS_W'(POS_SAT))
                    pos_next = pos_reg + POS_W'(1);
            end
        end

        rec_next.fmt_err = bad_now || (pos_reg != POS_W'(STR_LEN - 1));
        rec_next.cen     = pair_value(digit_next[0], digit_next[1]);
        rec_next.yy      = pair_value(digit_next[2], digit_next[3]);
        rec_next.mon     = pair_value(digit_next[4], digit_next[5]);
        rec_next.day     = pair_value(digit_next[6], digit_next[7]);
        rec_next.hr      = pair_value(digit_next[8], digit_next[9]);
        rec_next.mn      = pair_value(digit_next[10], digit_next[11]);
        rec_next.sc      = pair_value(digit_next[12], digit_next[13]);

        rec_valid_next = rec_valid_reg && !rec_ready;
        if (take && w_word.last_char)
            rec_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            bad_reg       <= 1'b0;
            rec_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            bad_reg       <= bad_next;
            rec_valid_reg <= rec_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            digit_reg <= digit_next;
        if (take && w_word.last_char)
            rec_reg <= rec_next;
    end

endmodule
`default_nettype wire

// ===== sv/dtscw_eval.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dtscw_eval: range check and weekday
// Checks each field against its calendar limit, computes the weekday from all
// four date pairs, and holds the result word for the output.
// ----------------------------------------------------------------------------
module dtscw_eval (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  rec_valid,
    input  dtscw_pkg::scan_rec_t       rec,
    output logic                       rec_ready,
    output logic                       res_valid,
    output dtscw_pkg::result_t         res,
    input  wire logic                  res_stall
);
    import dtscw_pkg::*;

    logic              res_valid_reg, res_valid_next;
    result_t           res_reg, res_next;
    logic              take;
    logic [YEAR_W-1:0] year_w;
    logic              leap;
    logic [DAY_W-1:0]  dim;
    logic              range_bad;
    logic              early;
    logic              borrow;
    logic [PAIR_W-1:0] cy;
    logic [PAIR_W-1:0] yr;
    logic [9:0]        wsum;
    logic [4:0]        fold1;
    logic [3:0]        fold2;
    logic [2:0]        wd;

    assign rec_ready = !res_valid_reg || !res_stall;
    assign take      = rec_valid && rec_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        year_w = YEAR_W'(rec.cen) * YEAR_W'(100) + YEAR_W'(rec.yy);
        leap   = (rec.yy != '0) ? (rec.yy[1:0] == 2'b00) : (rec.cen[1:0] == 2'b00);
        dim    = days_in_month(rec.mon, leap);
        range_bad = (rec.mon == '0) || (rec.mon > MAX_MONTH) || (rec.day == '0)
                 || (rec.day > PAIR_W'(dim)) || (rec.hr > MAX_HOURS)
                 || (rec.mn > MAX_MINUTES) || (rec.sc > MAX_SECONDS);

        // year offset by four centuries, January and February count to the year before
        early  = rec.mon < MONTH_MAR;
        borrow = early && (rec.yy == '0);
        cy     = rec.cen + (borrow ? 7'd3 : 7'd4);
        if (borrow)
            yr = MAX_YY;
        else if (early)
            yr = rec.yy - PAIR_W'(1);
        else
            yr = rec.yy;

        wsum  = 10'({cy, 2'b00}) + 10'(cy) + 10'(yr) + 10'(yr[6:2]) + 10'(cy[6:2])
              + 10'(month_offset(rec.mon)) + 10'(rec.day);
        fold1 = 5'(wsum[9]) + 5'(wsum[8:6]) + 5'(wsum[5:3]) + 5'(wsum[2:0]);
        fold2 = 4'(fold1[4:3]) + 4'(fold1[2:0]);
        wd    = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];

        res_next = '0;
        priority if (rec.fmt_err)
        begin
            res_next.status = STATUS_FORMAT;
        end
        else if (range_bad)
        begin
            res_next.status = STATUS_RANGE;
        end
        else
        begin
            res_next.status  = STATUS_VALID;
            res_next.year    = year_w;
            res_next.month   = rec.mon[MONTH_W-1:0];
            res_next.day     = rec.day[DAY_W-1:0];
            res_next.weekday = wd;
            res_next.hours   = rec.hr[HOURS_W-1:0];
            res_next.minutes = rec.mn[MINUTES_W-1:0];
            res_next.seconds = rec.sc[SECONDS_W-1:0];
        end

        res_valid_next = res_valid_reg && res_stall;
        if (take)
            res_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= res_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            res_reg <= res_next;
    end

endmodule
`default_nettype wire

// ===== verif/tb_datetime_string_check_weekday_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_datetime_string_check_weekday_unit: regression of the date-time checker
// Feeds "YYYY/MM/DD HH:MM:SS" strings one character word at a time, first
// from a directed table and then as random stamps, broken stamps and noise.
// A behavioral predictor works out each result word; every result is
// checked field by field in order, under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb_datetime_string_check_weekday_unit;
    import dtscw_pkg::*;

    localparam int unsigned HALF_PERIOD    = 10;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned HOLD_CYCLES    = 80;
    localparam int unsigned PHASE_CHARS    = 125;
    localparam int unsigned NUM_PHASES     = 4;
    localparam string       STAMP_SHAPE    = "DDDD/DD/DD DD:DD:DD";

    localparam int          SLOT_AT [STR_LEN] = '{0, 1, 2, 3, -1, 4, 5, -1, 6, 7, -1,
                                                 8, 9, -1, 10, 11, -1, 12, 13};
    localparam int unsigned WEEK_SHIFT [12]   = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};
    localparam int unsigned GAP_PCT [NUM_PHASES]   = '{0, 60, 0, 26};
    localparam int unsigned STALL_PCT [NUM_PHASES] = '{0, 0, 60, 26};

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [CHAR_W-1:0]      char_code = '0;
    logic                   last_char = 1'b0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [1:0]             status;
    logic [YEAR_W-1:0]      year;
    logic [MONTH_W-1:0]     month;
    logic [DAY_W-1:0]       day;
    logic [WEEKDAY_W-1:0]   weekday;
    logic [HOURS_W-1:0]     hours;
    logic [MINUTES_W-1:0]   minutes;
    logic [SECONDS_W-1:0]   seconds;

    // predictor state
    int unsigned            scan_pos;
    bit                     layout_broken;
    logic [3:0]             digit_mem [NUM_DIGITS];

    result_t                parsed_q [$];
    logic [CHAR_W-1:0]      line_q [$];
    string                  row_text [$];
    bit                     row_pinned [$];
    result_t                row_res [$];

    bit                     pinned;
    result_t                pinned_res;
    int unsigned            gap_pct;
    int unsigned            stall_pct;
    bit                     hold_req;
    int unsigned            hold_left;
    int unsigned            stuck_cycles;
    int unsigned            chars_taken;
    int unsigned            errors;
    int unsigned            n_valid;
    int unsigned            n_format;
    int unsigned            n_range;

    datetime_string_check_weekday_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .char_code (char_code),
        .last_char (last_char),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .year      (year),
        .month     (month),
        .day       (day),
        .weekday   (weekday),
        .hours     (hours),
        .minutes   (minutes),
        .seconds   (seconds)
    );

    initial
    begin
        forever
        begin
            #HALF_PERIOD clk = ~clk;
        end
    end

    function automatic int unsigned month_days(int unsigned yr, int unsigned mo);
        bit leap;
        leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
        case (mo)
            4, 6, 9, 11: return 30;
            2:           return leap ? 29 : 28;
            default:     return 31;
        endcase
    endfunction

    function automatic int unsigned two_digits(int unsigned k);
        return digit_mem[k] * 10 + digit_mem[k + 1];
    endfunction

    function automatic result_t bad_res(status_t s);
        result_t r;
        r = '0;
        r.status = s;
        return r;
    endfunction

    function automatic result_t ok_res(int unsigned yr, int unsigned mo, int unsigned dy,
                                       int unsigned wd, int unsigned hh, int unsigned mi,
                                       int unsigned ss);
        result_t r;
        r.status  = STATUS_VALID;
        r.year    = YEAR_W'(yr);
        r.month   = MONTH_W'(mo);
        r.day     = DAY_W'(dy);
        r.weekday = WEEKDAY_W'(wd);
        r.hours   = HOURS_W'(hh);
        r.minutes = MINUTES_W'(mi);
        r.seconds = SECONDS_W'(ss);
        return r;
    endfunction

    // advance the scanner by one word; on the last word queue the result
    function automatic void take_char(logic [CHAR_W-1:0] c, logic last);
        int unsigned p, yr, mo, dy, hh, mi, ss, y4;
        bit          len_ok;
        result_t     r;
        p = scan_pos;
        if (p < STR_LEN)
        begin
            if (SLOT_AT[p] >= 0)
            begin
                if (c >= CHAR_ZERO && c <= CHAR_NINE)
                    digit_mem[SLOT_AT[p]] = 4'(c - CHAR_ZERO);
                else
                    layout_broken = 1'b1;
            end
            else if (c != CHAR_W'(STAMP_SHAPE[p]))
            begin
                layout_broken = 1'b1;
            end
        end
        len_ok = (p == STR_LEN - 1);
        if (p < POS_SAT)
            scan_pos = p + 1;
        if (!last)
            return;
        if (!len_ok || layout_broken)
        begin
            r = bad_res(STATUS_FORMAT);
        end
        else
        begin
            yr = two_digits(0) * 100 + two_digits(2);
            mo = two_digits(4);
            dy = two_digits(6);
            hh = two_digits(8);
            mi = two_digits(10);
            ss = two_digits(12);
            if (mo < 1 || mo > 12 || dy < 1 || dy > month_days(yr, mo) ||
                hh > 23 || mi > 59 || ss > 59)
            begin
                r = bad_res(STATUS_RANGE);
            end
            else
            begin
                y4 = yr + 400 - ((mo < 3) ? 1 : 0);
                r = ok_res(yr, mo, dy,
                           (y4 + y4 / 4 - y4 / 100 + y4 / 400 + WEEK_SHIFT[mo - 1] + dy) % 7,
                           hh, mi, ss);
            end
        end
        if (pinned)
            r = pinned_res;
        pinned = 1'b0;
        parsed_q.push_back(r);
        scan_pos = 0;
        layout_broken = 1'b0;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    function automatic void check_result();
        result_t want;
        if (parsed_q.size() == 0)
        begin
            errors++;
            $display("%0t: result word with none expected, actual status %0d", $time, status);
            return;
        end
        want = parsed_q.pop_front();
        check_field("status", want.status, status);
        check_field("year", want.year, year);
        check_field("month", want.month, month);
        check_field("day", want.day, day);
        check_field("weekday", want.weekday, weekday);
        check_field("hours", want.hours, hours);
        check_field("minutes", want.minutes, minutes);
        check_field("seconds", want.seconds, seconds);
        case (want.status)
            STATUS_VALID:  n_valid++;
            STATUS_FORMAT: n_format++;
            default:       n_range++;
        endcase
    endfunction

    always @(posedge clk)
    begin
        bit moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (in_valid && in_stall === 1'b0)
            begin
                take_char(char_code, last_char);
                chars_taken++;
                moved = 1'b1;
            end
            if (out_valid === 1'b1 && !out_stall)
            begin
                check_result();
                moved = 1'b1;
            end
            stuck_cycles = moved ? 0 : stuck_cycles + 1;
        end
    end

    initial
    begin
        while (stuck_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("datetime_string_check_weekday_unit regression: fail");
        $finish;
    end

    // receiver: random stall, or a long hold-off on request
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // called and returns at a falling edge
    task automatic put_word(logic [CHAR_W-1:0] c, logic last);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= c;
        last_char <= last;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        @(negedge clk);
    endtask

    task automatic send_line();
        for (int i = 0; i < line_q.size(); i++)
            put_word(line_q[i], i == line_q.size() - 1);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (parsed_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic void load_text(string s);
        line_q.delete();
        for (int i = 0; i < s.len(); i++)
            line_q.push_back(s[i]);
    endfunction

    function automatic void add_row(string s, bit pin, result_t r);
        row_text.push_back(s);
        row_pinned.push_back(pin);
        row_res.push_back(r);
    endfunction

    function automatic void fill_stamp();
        int unsigned yr, mo, dy, hh, mi, ss, r;
        yr = $urandom_range(0, 9999);
        mo = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12) : $urandom_range(0, 99);
        r  = $urandom_range(0, 99);
        dy = (r < 30) ? $urandom_range(28, 31) :
             (r < 90) ? $urandom_range(1, 31) : $urandom_range(0, 99);
        hh = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 23) : $urandom_range(0, 99);
        mi = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 59) : $urandom_range(0, 99);
        ss = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 59) : $urandom_range(0, 99);
        case ($urandom_range(0, 9))
            0: yr = 400 * $urandom_range(0, 24);
            1: yr = 100 * $urandom_range(0, 99);
            2: yr = 4 * $urandom_range(0, 2499);
            default: ;
        endcase
        if ($urandom_range(0, 3) == 0)
        begin
            mo = 2;
            dy = $urandom_range(28, 30);
        end
        load_text($sformatf("%04d/%02d/%02d %02d:%02d:%02d", yr, mo, dy, hh, mi, ss));
    endfunction

    function automatic void fill_random_line();
        int unsigned r, n;
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            fill_stamp();
        end
        else if (r < 85)
        begin
            fill_stamp();
            case ($urandom_range(0, 2))
                0: line_q[$urandom_range(0, STR_LEN - 1)] = CHAR_W'($urandom_range(0, 255));
                1:
                begin
                    n = $urandom_range(1, STR_LEN - 1);
                    while (line_q.size() > n)
                        void'(line_q.pop_back());
                end
                default:
                    repeat ($urandom_range(1, 6))
                        line_q.push_back(CHAR_W'($urandom_range(0, 255)));
            endcase
        end
        else
        begin
            line_q.delete();
            repeat ($urandom_range(1, 24))
                line_q.push_back(CHAR_W'($urandom_range(0, 255)));
        end
    endfunction

    initial
    begin
        int unsigned goal;
        scan_pos = 0;
        layout_broken = 1'b0;
        foreach (digit_mem[k])
            digit_mem[k] = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        add_row("7", 1, bad_res(STATUS_FORMAT));
        add_row("0000/01/01 00:00:00", 1, ok_res(0, 1, 1, 6, 0, 0, 0));
        add_row("9999/12/31 23:59:59", 1, ok_res(9999, 12, 31, 5, 23, 59, 59));
        add_row("2000/02/29 12:34:56", 1, ok_res(2000, 2, 29, 2, 12, 34, 56));
        add_row("1900/02/29 00:00:00", 1, bad_res(STATUS_RANGE));
        add_row("2023/02/29 08:00:00", 1, bad_res(STATUS_RANGE));
        add_row("2024/02/29 08:00:00", 0, '0);
        add_row("1600/02/29 10:20:30", 0, '0);
        add_row("2023/04/31 00:00:00", 1, bad_res(STATUS_RANGE));
        add_row("2023/13/01 00:00:00", 1, bad_res(STATUS_RANGE));
        add_row("2023/00/10 00:00:00", 1, bad_res(STATUS_RANGE));
        add_row("2023/01/00 00:00:00", 1, bad_res(STATUS_RANGE));
        add_row("2023/01/01 24:00:00", 1, bad_res(STATUS_RANGE));
        add_row("2023/01/01 00:60:00", 1, bad_res(STATUS_RANGE));
        add_row("2023/01/01 00:00:60", 1, bad_res(STATUS_RANGE));
        add_row("2023/1/01 00:00:00", 1, bad_res(STATUS_FORMAT));
        add_row("2023/01/01 00:00:000", 1, bad_res(STATUS_FORMAT));
        add_row("2023/01/01 00:00:00000000", 1, bad_res(STATUS_FORMAT));
        add_row("2023-01-01 00:00:00", 1, bad_res(STATUS_FORMAT));
        add_row("2023/01/01T00:00:00", 1, bad_res(STATUS_FORMAT));
        add_row("2023/01/01 00.00:00", 1, bad_res(STATUS_FORMAT));
        add_row("2a23/01/01 00:00:00", 1, bad_res(STATUS_FORMAT));
        add_row("/023/01/01 00:00:00", 1, bad_res(STATUS_FORMAT));
        add_row("2023/01/01 00:00:5:", 1, bad_res(STATUS_FORMAT));
        add_row("2023/12/31 23:59:59", 0, '0);

        gap_pct = 0;
        stall_pct = 0;
        foreach (row_text[i])
        begin
            load_text(row_text[i]);
            pinned_res = row_res[i];
            pinned = row_pinned[i];
            send_line();
        end
        settle();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            gap_pct = GAP_PCT[ph];
            stall_pct = STALL_PCT[ph];
            if (ph == 0)
            begin
                // hold the receiver while one-word strings pile up
                hold_req = 1'b1;
                repeat (30)
                    put_word(CHAR_W'($urandom_range(0, 255)), 1'b1);
                settle();
            end
            goal = chars_taken + PHASE_CHARS;
            while (chars_taken < goal)
            begin
                fill_random_line();
                send_line();
            end
            settle();
        end

        $display("checked %0d result words from %0d character words:",
                 n_valid + n_format + n_range, chars_taken);
        $display("%0d valid, %0d format, %0d range; idle mixes: none, sender 60%%, %s",
                 n_valid, n_format, n_range,
                 "receiver 60%, both 26%, plus a long receiver hold");
        if (errors == 0)
            $display("datetime_string_check_weekday_unit regression: pass");
        else
            $display("datetime_string_check_weekday_unit regression: fail");
        $finish;
    end

endmodule
`default_nettype wire
